// ===== design/plc_pkg.sv =====
// Shared types and constants for the piecewise-linear calibrator.
`timescale 1ns / 1ps
package plc_pkg;
    localparam int TABLE_POINTS = 16;
    localparam int IDX_W = $clog2(TABLE_POINTS);
    localparam int CNT_W = 5;
    localparam int DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        CMD_CONVERT = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    // One request as it travels from the front part to the back part.
    typedef struct packed {
        t_cmd cmd;
        logic [IDX_W-1:0] idx;
        logic signed [DATA_W-1:0] raw_point;
        logic signed [DATA_W-1:0] real_point;
        logic signed [DATA_W-1:0] measured;
    } t_req;
endpackage

// ===== design/piecewise_linear_calibrator_core.sv =====
// Each convert searches the segments in turn, then reloads the chosen segment, sets up,
// runs a 66-step serial divide and registers the output; with fewer than two points the
// result comes straight from the search, and a zero raw span skips the divide.
// A write point request is taken by the back part while idle; the queue holds two.
// Converts run one at a time. Synchronous active-low reset clears the point count,
// queue and sequencer; the calibration tables are not cleared.
`timescale 1ns / 1ps
module piecewise_linear_calibrator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [3:0]  i_point_index,
    input  logic signed [31:0] i_raw_point,
    input  logic signed [31:0] i_real_point,
    input  logic signed [31:0] i_measured,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_calibrated,
    output logic        o_saturated,
    output logic        o_extrapolated
);
    import plc_pkg::*;

    logic [CNT_W-1:0] r_point_count;
    t_req in_req, q_req;
    logic q_valid, q_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_point_count <= '0;
        else if (i_cfg_we) r_point_count <= i_cfg_wdata;
    end

    assign in_req = '{cmd: t_cmd'(i_command), idx: i_point_index,
                      raw_point: i_raw_point, real_point: i_real_point,
                      measured: i_measured};

    plc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req(in_req),
        .o_req_valid(q_valid), .i_req_take(q_take), .o_req(q_req));

    plc_back u_back (
        .i_clk, .i_rst_n, .i_point_count(r_point_count),
        .i_req_valid(q_valid), .o_req_take(q_take), .i_req(q_req),
        .o_valid, .i_stall, .o_calibrated, .o_saturated, .o_extrapolated);
endmodule

// ===== design/plc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module plc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/plc_front.sv =====
// Front part: accepts requests into a short queue ahead of the back part.
`timescale 1ns / 1ps
module plc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  plc_pkg::t_req i_req,
    output logic          o_req_valid,
    input  logic          i_req_take,
    output plc_pkg::t_req o_req
);
    import plc_pkg::*;

    t_req r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0] r_cnt;
    logic push, pop;

    assign o_stall = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign push = i_valid && !o_stall;
    assign o_req_valid = (r_cnt != '0);
    assign pop = o_req_valid && i_req_take;
    assign o_req = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end
endmodule

// ===== design/plc_muldiv.sv =====
// Unsigned 33-bit multiply, then serial restoring division with a capped quotient.
`timescale 1ns / 1ps
module plc_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    input  logic [32:0] i_d,
    output logic        o_done,
    output logic [36:0] o_q
);
    // Magnitudes are at most 2^32, product below 2^65; quotient capped at 2^36.
    logic [65:0] r_num;
    logic [32:0] r_den;
    logic [33:0] r_rem;
    logic [65:0] r_quo;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [33:0] n_rem;
    logic [34:0] diff;

    assign n_rem = {r_rem[32:0], r_num[65]};
    assign diff = {1'b0, n_rem} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num <= 66'(i_a) * 66'(i_b);
                r_den <= i_d;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 7'd65;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[64:0], 1'b0};
                if (!diff[34]) begin
                    r_rem <= diff[33:0];
                    r_quo <= {r_quo[64:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[64:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q = (r_quo > 66'(37'h10_0000_0000)) ? 37'h10_0000_0000 : r_quo[36:0];
endmodule

// ===== design/plc_back.sv =====
// Back part: table writes, segment search and interpolation sequencer.
`timescale 1ns / 1ps
module plc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [plc_pkg::CNT_W-1:0]    i_point_count,
    input  logic                         i_req_valid,
    output logic                         o_req_take,
    input  plc_pkg::t_req                i_req,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [plc_pkg::DATA_W-1:0] o_calibrated,
    output logic                         o_saturated,
    output logic                         o_extrapolated
);
    import plc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SRCH  = 7'b0000010,
        ST_CHK   = 7'b0000100,
        ST_LD    = 7'b0001000,
        ST_PREP  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    t_req   r_req;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_i, r_seg, r_anchor;
    logic [1:0] r_sub;
    logic signed [DATA_W-1:0] r_raw_a, r_raw_b, r_real_a, r_raw_first;
    logic signed [DATA_W-1:0] r_base;
    logic signed [DATA_W-1:0] meas;
    logic r_ext;
    logic [IDX_W-1:0] raddr;
    logic signed [DATA_W-1:0] raw_rd, real_rd;
    logic tbl_we;
    logic signed [37:0] r_res;
    logic signed [37:0] q_ext;
    logic r_out_valid;
    logic out_free;
    logic signed [DATA_W-1:0] r_out_cal;
    logic r_out_sat, r_out_ext;
    logic md_start, md_done;
    logic [32:0] md_a, md_b, md_d;
    logic [36:0] md_q;
    logic r_neg;
    logic signed [32:0] r_dreal, r_dm, r_span;

    assign meas = r_req.measured;
    assign tbl_we = (r_state == ST_IDLE) && i_req_valid && i_req.cmd == CMD_WRITE;
    assign o_req_take = (r_state == ST_IDLE) && i_req_valid
                        && (i_req.cmd == CMD_WRITE || !r_out_valid);
    assign out_free = !r_out_valid || !i_stall;

    plc_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_POINTS)) u_raw (
        .i_clk, .i_we(tbl_we), .i_waddr(i_req.idx), .i_wdata(i_req.raw_point),
        .i_raddr(raddr), .o_rdata(raw_rd));
    plc_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_POINTS)) u_real (
        .i_clk, .i_we(tbl_we), .i_waddr(i_req.idx), .i_wdata(i_req.real_point),
        .i_raddr(raddr), .o_rdata(real_rd));

    // In the search, sub-step 0 reads point i and sub-step 1 reads point i+1; the reload reads the segment's ends.
    always_comb begin
        raddr = r_i;
        if (r_state == ST_SRCH && r_sub[0]) raddr = r_i + 1'b1;
        if (r_state == ST_LD) raddr = (r_sub == 2'd0) ? r_seg : r_seg + 1'b1;
    end

    assign md_a = r_dreal[32] ? 33'(-r_dreal) : 33'(r_dreal);
    assign md_b = r_dm[32] ? 33'(-r_dm) : 33'(r_dm);
    assign md_d = r_span[32] ? 33'(-r_span) : 33'(r_span);
    assign md_start = (r_state == ST_PREP) && (r_span != '0);
    assign q_ext = $signed({1'b0, md_q});

    plc_muldiv u_md (
        .i_clk, .i_rst_n, .i_start(md_start), .i_a(md_a), .i_b(md_b), .i_d(md_d),
        .o_done(md_done), .o_q(md_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_req_take && i_req.cmd == CMD_CONVERT) begin
                        r_req <= i_req;
                        r_cnt <= (i_point_count > CNT_W'(TABLE_POINTS))
                                 ? CNT_W'(TABLE_POINTS) : i_point_count;
                        r_i <= '0;
                        r_sub <= '0;
                        r_ext <= 1'b0;
                        r_state <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    // Reads are pipelined: the RAM registers its read data.
                    r_sub <= r_sub + 1'b1;
                    if (r_sub == 2'd1) begin
                        r_raw_a <= raw_rd;
                        if (r_cnt < CNT_W'(2)) begin
                            r_res <= (r_cnt == '0) ? 38'(meas) : 38'(real_rd);
                            r_state <= ST_OUT;
                        end
                    end
                    if (r_sub == 2'd2) begin
                        r_raw_b <= raw_rd;
                        if (r_i == '0) r_raw_first <= r_raw_a;
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    r_sub <= '0;
                    if (meas >= r_raw_a && meas <= r_raw_b) begin
                        r_seg <= r_i;
                        r_anchor <= r_i;
                        r_state <= ST_LD;
                    end else if (33'(r_i) + 33'd2 >= 33'(r_cnt)) begin
                        r_ext <= 1'b1;
                        if (meas < r_raw_first) begin
                            r_i <= '0;
                            r_seg <= '0;
                            r_anchor <= '0;
                        end else begin
                            r_seg <= r_i;
                            r_anchor <= r_i + 1'b1;
                        end
                        r_state <= ST_LD;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= ST_SRCH;
                    end
                end
                ST_LD: begin
                    // Reload the chosen segment's start and end points.
                    r_sub <= r_sub + 1'b1;
                    if (r_sub == 2'd1) begin
                        r_raw_a <= raw_rd;
                        r_real_a <= real_rd;
                    end
                    if (r_sub == 2'd2) begin
                        r_span <= 33'(raw_rd) - 33'(r_raw_a);
                        r_dreal <= 33'(real_rd) - 33'(r_real_a);
                        if (r_anchor == r_seg) begin
                            r_base <= r_real_a;
                            r_dm <= 33'(meas) - 33'(r_raw_a);
                        end else begin
                            r_base <= real_rd;
                            r_dm <= 33'(meas) - 33'(raw_rd);
                        end
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_neg <= r_dreal[32] ^ r_dm[32] ^ r_span[32];
                    // Zero raw span returns the segment's start point without dividing.
                    if (r_span == '0) begin
                        r_res <= 38'(r_real_a);
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (md_done) begin
                        r_res <= r_neg ? 38'(r_base) - q_ext : 38'(r_base) + q_ext;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_ext <= r_ext;
                        if (r_res > 38'sd2147483647) begin
                            r_out_cal <= 32'h7FFF_FFFF;
                            r_out_sat <= 1'b1;
                        end else if (r_res < -38'sd2147483648) begin
                            r_out_cal <= 32'h8000_0000;
                            r_out_sat <= 1'b1;
                        end else begin
                            r_out_cal <= r_res[31:0];
                            r_out_sat <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_calibrated = r_out_cal;
    assign o_saturated = r_out_sat;
    assign o_extrapolated = r_out_ext;
endmodule

// ===== design/plc_checker.sv =====
// Port-level checks for the calibrator, bound to the top level.
`timescale 1ns / 1ps
module plc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_saturated,
    input logic [31:0] o_calibrated
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_calibrated))
        else $error("stalled result changed");
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_calibrated == 32'h7FFF_FFFF
                                   || o_calibrated == 32'h8000_0000)
        else $error("saturated result not at a limit");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");
endmodule

bind piecewise_linear_calibrator_core plc_checker u_checker (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall,
    .o_saturated, .o_calibrated);
